// ===== rtl/gcp_pkg.sv =====
// gcp_pkg: shared types and constants of the geometry command port buffer
// no dependencies; imported by the interfaces and by every module

package gcp_pkg;

  // buffer geometry
  localparam int unsigned BUFFER_WORDS = 32768;
  localparam int unsigned ADDR_W       = $clog2(BUFFER_WORDS);
  localparam int unsigned PTR_W        = 20;

  // field widths
  localparam int unsigned ACTION_W = 3;
  localparam int unsigned OFFSET_W = 12;
  localparam int unsigned INDEX_W  = 15;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned ERROR_W  = 2;

  // fill pattern of the buffer after reset
  localparam logic [DATA_W-1:0] FILL_WORD = 32'h0780_0f0f;

  // command word packing
  localparam logic [DATA_W-1:0] CMD_KEEP_TOP = 32'h800f_ffff;
  localparam logic [DATA_W-1:0] CMD_KEEP_LOW = 32'h000f_ffff;
  localparam int unsigned       CMD_REG_LSB  = 23;
  localparam int unsigned       CMD_BANK_LSB = 29;

  // port window offsets
  localparam logic [OFFSET_W-1:0] OFF_CMD_LIMIT = 12'h400;
  localparam logic [OFFSET_W-1:0] OFF_WP_LOAD   = 12'h402;
  localparam logic [OFFSET_W-1:0] OFF_WP_READ   = 12'h802;
  localparam logic [OFFSET_W-1:0] OFF_RP        = 12'hC02;

  // request actions
  typedef enum logic [ACTION_W-1:0] {
    ACT_PORT_WR = 3'd0,
    ACT_PORT_RD = 3'd1,
    ACT_PROG_WR = 3'd2,
    ACT_BUF_WR  = 3'd3,
    ACT_BUF_RD  = 3'd4
  } gcp_action_e;

  // error codes
  typedef enum logic [ERROR_W-1:0] {
    ERR_NONE     = 2'd0,
    ERR_UNKNOWN  = 2'd1,
    ERR_PAST_END = 2'd2
  } gcp_error_e;

  // request payload
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [OFFSET_W-1:0] port_offset;
    logic [INDEX_W-1:0]  buffer_index;
    logic [DATA_W-1:0]   write_data;
    logic [DATA_W-1:0]   lane_mask;
  } gcp_req_t;

  // controller to datapath
  typedef struct packed {
    logic clear;  // write fill word at the clear counter
    logic load;   // capture request and read the buffer
    logic exec;   // carry out the captured request
  } gcp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;  // clear counter at the last word
  } gcp_sts_t;

endpackage

// ===== rtl/gcp_req_if.sv =====
// gcp_req_if: request channel of the geometry command port
// depends on gcp_pkg

interface gcp_req_if;
  import gcp_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [OFFSET_W-1:0] port_offset;
  logic [INDEX_W-1:0]  buffer_index;
  logic [DATA_W-1:0]   write_data;
  logic [DATA_W-1:0]   lane_mask;

  modport source (
    output valid, action, port_offset, buffer_index, write_data, lane_mask,
    input  ready
  );

  modport sink (
    input  valid, action, port_offset, buffer_index, write_data, lane_mask,
    output ready
  );
endinterface

// ===== rtl/gcp_rsp_if.sv =====
// gcp_rsp_if: response channel of the geometry command port
// depends on gcp_pkg

interface gcp_rsp_if;
  import gcp_pkg::*;

  logic               valid;
  logic               ready;
  logic [DATA_W-1:0]  read_data;
  logic [ERROR_W-1:0] error_code;

  modport source (
    output valid, read_data, error_code,
    input  ready
  );

  modport sink (
    input  valid, read_data, error_code,
    output ready
  );
endinterface

// ===== rtl/gcp_ctrl.sv =====
// gcp_ctrl: sequencer of the geometry command port (clear, accept, execute, respond)
// depends on gcp_pkg

module gcp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  input  gcp_pkg::gcp_sts_t sts_i,
  output gcp_pkg::gcp_cmd_t cmd_o
);
  import gcp_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_EXEC  = 4'b0100,
    S_RESP  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = (state_q == S_RESP);
  assign accept      = req_valid_i && req_ready_o;

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o.clear = 1'b0;
    cmd_o.load  = 1'b0;
    cmd_o.exec  = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_RESP;
      end
      S_RESP: begin
        if (rsp_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/gcp_datapath.sv =====
// gcp_datapath: buffer memory, pointers, command packing and result registers
// depends on gcp_pkg; driven by gcp_ctrl

module gcp_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_wdata_i,
  input  gcp_pkg::gcp_req_t            req_i,
  input  gcp_pkg::gcp_cmd_t            cmd_i,
  output gcp_pkg::gcp_sts_t            sts_o,
  output logic [gcp_pkg::DATA_W-1:0]   read_data_o,
  output logic [gcp_pkg::ERROR_W-1:0]  error_code_o
);
  import gcp_pkg::*;

  // buffer memory
  logic [DATA_W-1:0] mem [BUFFER_WORDS];
  logic [DATA_W-1:0] mem_rdata_q;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [DATA_W-1:0] mem_wdata;

  // state
  logic              hold_q;
  logic [PTR_W-1:0]  wp_q, wp_d;
  logic [PTR_W-1:0]  rp_q, rp_d;
  logic [ADDR_W-1:0] clr_cnt_q;
  gcp_req_t          req_q;
  logic [DATA_W-1:0] rd_q, rd_d;
  logic [ERROR_W-1:0] err_q, err_d;

  // decode helpers
  logic [5:0]          reg_sel;
  logic [1:0]          bank;
  logic                push;
  logic [DATA_W-1:0]   push_word;
  logic [PTR_W-3:0]    slot;
  logic                full;
  logic                idx_ok;

  assign reg_sel = req_q.port_offset[7:2];
  assign bank    = req_q.port_offset[9:8];
  assign slot    = wp_q[PTR_W-1:2];
  assign full    = 32'(slot) >= 32'(BUFFER_WORDS);
  assign idx_ok  = 32'(req_q.buffer_index) < 32'(BUFFER_WORDS);

  assign sts_o.clear_last = (clr_cnt_q == ADDR_W'(BUFFER_WORDS - 1));

  // execute the captured request
  always_comb begin
    wp_d      = wp_q;
    rp_d      = rp_q;
    rd_d      = '0;
    err_d     = ERR_NONE;
    push      = 1'b0;
    push_word = '0;
    mem_we    = 1'b0;
    mem_waddr = clr_cnt_q;
    mem_wdata = FILL_WORD;
    if (cmd_i.clear) begin
      mem_we = 1'b1;
    end else if (cmd_i.exec) begin
      case (req_q.action)
        ACT_PORT_WR: begin
          if (req_q.port_offset < OFF_CMD_LIMIT) begin
            if (req_q.write_data[DATA_W-1]) begin
              push      = 1'b1;
              push_word = (req_q.write_data & CMD_KEEP_TOP)
                        | (DATA_W'(reg_sel) << CMD_REG_LSB);
            end else if (req_q.port_offset[1:0] == 2'b00) begin
              push      = 1'b1;
              push_word = (req_q.write_data & CMD_KEEP_LOW)
                        | (DATA_W'(reg_sel) << CMD_REG_LSB);
              // bank number for register one
              if (reg_sel == 6'd1 && bank != 2'd0) begin
                push_word = push_word | (DATA_W'(bank) << CMD_BANK_LSB);
              end
            end
          end else if (req_q.port_offset == OFF_WP_LOAD) begin
            wp_d = req_q.write_data[PTR_W-1:0];
          end else if (req_q.port_offset == OFF_RP) begin
            rp_d = req_q.write_data[PTR_W-1:0];
          end else begin
            err_d = ERR_UNKNOWN;
          end
        end
        ACT_PORT_RD: begin
          if (req_q.port_offset == OFF_WP_READ) begin
            rd_d = DATA_W'(wp_q);
          end else if (req_q.port_offset == OFF_RP) begin
            rd_d = DATA_W'(rp_q);
          end
        end
        ACT_PROG_WR: begin
          if (!hold_q) begin
            push      = 1'b1;
            push_word = req_q.write_data;
          end
        end
        ACT_BUF_WR: begin
          if (idx_ok) begin
            mem_we    = 1'b1;
            mem_waddr = ADDR_W'(req_q.buffer_index);
            mem_wdata = (mem_rdata_q & ~req_q.lane_mask)
                      | (req_q.write_data & req_q.lane_mask);
          end
        end
        ACT_BUF_RD: begin
          if (idx_ok) begin
            rd_d = mem_rdata_q;
          end
        end
        default: begin
        end
      endcase
      // append at the write pointer
      if (push) begin
        if (full) begin
          err_d = ERR_PAST_END;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = ADDR_W'(slot);
          mem_wdata = push_word;
          wp_d      = wp_q + PTR_W'(4);
        end
      end
    end
  end

  // memory write and registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.load) begin
      mem_rdata_q <= mem[ADDR_W'(req_i.buffer_index)];
    end
  end

  // request capture and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    if (cmd_i.exec) begin
      rd_q  <= rd_d;
      err_q <= err_d;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q    <= 1'b0;
      wp_q      <= '0;
      rp_q      <= '0;
      clr_cnt_q <= '0;
    end else begin
      if (cfg_we_i) begin
        hold_q <= cfg_wdata_i;
      end
      if (cmd_i.clear) begin
        clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
      end
      wp_q <= wp_d;
      rp_q <= rp_d;
    end
  end

  assign read_data_o  = rd_q;
  assign error_code_o = err_q;

endmodule

// ===== rtl/geometry_command_port_buffer.sv =====
// geometry_command_port_buffer: response valid once the accepted request has gone
// from the execute state into the respond state; no new request is taken until the
// response is accepted (accept, execute, respond), set by the single-port buffer
// read then write sequence of the controller
// reset: pointers and program hold clear; the buffer is filled with the fill word in a
// clearing pass over all BUFFER_WORDS words (32768), during which no request is accepted
// depends on gcp_pkg, gcp_req_if, gcp_rsp_if, gcp_ctrl, gcp_datapath

module geometry_command_port_buffer (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i,
  gcp_req_if.sink       req_i,
  gcp_rsp_if.source     rsp_o
);
  import gcp_pkg::*;

  gcp_cmd_t cmd;
  gcp_sts_t sts;
  gcp_req_t req;

  // request payload
  assign req.action       = req_i.action;
  assign req.port_offset  = req_i.port_offset;
  assign req.buffer_index = req_i.buffer_index;
  assign req.write_data   = req_i.write_data;
  assign req.lane_mask    = req_i.lane_mask;

  gcp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  gcp_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .req_i        (req),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .read_data_o  (rsp_o.read_data),
    .error_code_o (rsp_o.error_code)
  );

endmodule

// ===== tb/tb.sv =====
// tb: self-checking testbench of geometry_command_port_buffer
// depends on gcp_pkg, gcp_req_if, gcp_rsp_if and the block itself
`timescale 1ns / 100ps

module tb;
  import gcp_pkg::*;

  // spare action codes that the block must ignore
  localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;

  typedef struct {
    logic [DATA_W-1:0]  rd;
    logic [ERROR_W-1:0] err;
  } reply_t;

  typedef struct {
    logic [ACTION_W-1:0] act;
    logic [OFFSET_W-1:0] off;
    logic [INDEX_W-1:0]  idx;
    logic [DATA_W-1:0]   data;
    logic [DATA_W-1:0]   mask;
    bit                  hold;
    bit                  typed;
    logic [DATA_W-1:0]   rd;
    logic [ERROR_W-1:0]  err;
  } probe_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic cfg_wdata;

  gcp_req_if req_bus ();
  gcp_rsp_if rsp_bus ();

  geometry_command_port_buffer i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_bus),
    .rsp_o       (rsp_bus)
  );

  // shadow copy of the buffer, pointers and hold bit
  logic [DATA_W-1:0] buf_img [BUFFER_WORDS];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  bit                hold_bit;

  reply_t     owed_replies[$];
  probe_row_t probe_rows[$];

  int mismatches   = 0;
  int replies_seen = 0;
  int tx_rate      = 0;
  bit calm         = 1'b0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #5000000;
    $display("tb failed");
    $finish;
  end

  // append one word at the write pointer
  function automatic logic [ERROR_W-1:0] append_word(logic [DATA_W-1:0] w);
    if ((wr_ptr >> 2) >= BUFFER_WORDS) return ERR_PAST_END;
    buf_img[wr_ptr[ADDR_W+1:2]] = w;
    wr_ptr = wr_ptr + PTR_W'(4);
    return ERR_NONE;
  endfunction

  // predicted reply of one request, updating the shadow state
  task automatic apply_request(input gcp_req_t r, output logic [DATA_W-1:0] rd,
                               output logic [ERROR_W-1:0] err);
    logic [5:0]        reg_sel;
    logic [1:0]        bank;
    logic [DATA_W-1:0] cmd;
    rd  = '0;
    err = ERR_NONE;
    reg_sel = r.port_offset[7:2];
    bank    = r.port_offset[9:8];
    case (r.action)
      ACT_PORT_WR: begin
        if (r.port_offset < OFF_CMD_LIMIT) begin
          if (r.write_data[31]) begin
            err = append_word((r.write_data & CMD_KEEP_TOP) |
                              (DATA_W'(reg_sel) << CMD_REG_LSB));
          end else if (r.port_offset[1:0] == 2'b00) begin
            cmd = (r.write_data & CMD_KEEP_LOW) | (DATA_W'(reg_sel) << CMD_REG_LSB);
            // bank number rides along only for register 1
            if (bank != 2'd0 && reg_sel == 6'd1) cmd |= DATA_W'(bank) << CMD_BANK_LSB;
            err = append_word(cmd);
          end
        end else if (r.port_offset == OFF_WP_LOAD) begin
          wr_ptr = r.write_data[PTR_W-1:0];
        end else if (r.port_offset == OFF_RP) begin
          rd_ptr = r.write_data[PTR_W-1:0];
        end else begin
          err = ERR_UNKNOWN;
        end
      end
      ACT_PORT_RD: begin
        if (r.port_offset == OFF_WP_READ) rd = DATA_W'(wr_ptr);
        else if (r.port_offset == OFF_RP) rd = DATA_W'(rd_ptr);
      end
      ACT_PROG_WR: begin
        if (!hold_bit) err = append_word(r.write_data);
      end
      ACT_BUF_WR: begin
        if (r.buffer_index < BUFFER_WORDS)
          buf_img[r.buffer_index] = (buf_img[r.buffer_index] & ~r.lane_mask) |
                                    (r.write_data & r.lane_mask);
      end
      ACT_BUF_RD: begin
        if (r.buffer_index < BUFFER_WORDS) rd = buf_img[r.buffer_index];
      end
      default: begin
      end
    endcase
  endtask

  // offer one request, wait for it to be taken, then predict its reply
  task automatic send_request(input gcp_req_t r, output logic [DATA_W-1:0] rd,
                              output logic [ERROR_W-1:0] err);
    int gap;
    gap = 0;
    if (!calm && tx_rate != 0 && $urandom_range(1, 8) <= tx_rate) gap = $urandom_range(1, 7);
    if (gap != 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_bus.valid        <= 1'b1;
    req_bus.action       <= r.action;
    req_bus.port_offset  <= r.port_offset;
    req_bus.buffer_index <= r.buffer_index;
    req_bus.write_data   <= r.write_data;
    req_bus.lane_mask    <= r.lane_mask;
    do @(posedge clk_i); while (req_bus.ready !== 1'b1);
    apply_request(r, rd, err);
  endtask

  // drain outstanding replies, then write the hold bit
  task automatic set_program_hold(input bit v);
    req_bus.valid <= 1'b0;
    while (owed_replies.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    hold_bit  = v;
  endtask

  function automatic void add_probe(logic [ACTION_W-1:0] act, logic [OFFSET_W-1:0] off,
                                    logic [INDEX_W-1:0] idx, logic [DATA_W-1:0] data,
                                    logic [DATA_W-1:0] mask, bit hold, bit typed,
                                    logic [DATA_W-1:0] rd, logic [ERROR_W-1:0] err);
    probe_row_t p;
    p.act = act; p.off = off; p.idx = idx; p.data = data; p.mask = mask;
    p.hold = hold; p.typed = typed; p.rd = rd; p.err = err;
    probe_rows.insert(probe_rows.size(), p);
  endfunction

  // buffer index: mostly a small window, sometimes just below the write pointer
  function automatic logic [INDEX_W-1:0] pick_index();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return INDEX_W'($urandom_range(0, 300));
    if (sel < 85) return INDEX_W'((wr_ptr >> 2) - $urandom_range(0, 4));
    return INDEX_W'($urandom);
  endfunction

  // random request, weighted toward pushes and reads that hit pushed words
  function automatic gcp_req_t random_request();
    gcp_req_t r;
    int       sel;
    r.action       = ACTION_W'($urandom);
    r.port_offset  = OFFSET_W'($urandom);
    r.buffer_index = INDEX_W'($urandom);
    r.write_data   = $urandom;
    r.lane_mask    = $urandom;
    sel = $urandom_range(0, 99);
    if (sel < 30) begin
      r.action = ACT_PORT_WR;
      if ($urandom_range(0, 3) == 0)
        r.port_offset = {2'b00, 2'($urandom), 6'd1, 2'b00};
      else
        r.port_offset = OFFSET_W'($urandom_range(0, 12'h3ff));
    end else if (sel < 38) begin
      r.action = ACT_PORT_WR;
      r.port_offset = OFF_WP_LOAD;
      if ($urandom_range(0, 4) != 0)
        r.write_data[PTR_W-1:0] = PTR_W'($urandom_range(0, 1023));
      else if ($urandom_range(0, 1) == 0)
        r.write_data[PTR_W-1:0] = PTR_W'($urandom_range(20'h1ffe0, 20'h20020));
    end else if (sel < 42) begin
      r.action = ACT_PORT_WR;
      r.port_offset = OFF_RP;
    end else if (sel < 47) begin
      r.action = ACT_PORT_WR;
    end else if (sel < 57) begin
      r.action = ACT_PORT_RD;
      case ($urandom_range(0, 2))
        0: r.port_offset = OFF_WP_READ;
        1: r.port_offset = OFF_RP;
        default: begin
        end
      endcase
    end else if (sel < 70) begin
      r.action = ACT_PROG_WR;
    end else if (sel < 82) begin
      r.action = ACT_BUF_WR;
      r.buffer_index = pick_index();
      case ($urandom_range(0, 5))
        0: r.lane_mask = '0;
        1: r.lane_mask = '1;
        default: begin
        end
      endcase
    end else if (sel < 97) begin
      r.action = ACT_BUF_RD;
      r.buffer_index = pick_index();
    end else begin
      r.action = ACTION_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
    end
    return r;
  endfunction

  // directed requests
  function automatic void build_probe_table();
    // state after reset
    add_probe(ACT_PORT_RD, OFF_WP_READ, '0, '0, '0, 0, 1, '0, ERR_NONE);
    add_probe(ACT_PORT_RD, OFF_RP, '0, '0, '0, 0, 1, '0, ERR_NONE);
    add_probe(ACT_BUF_RD, '0, '0, '1, '1, 0, 1, FILL_WORD, ERR_NONE);
    add_probe(ACT_BUF_RD, '1, '1, '0, '0, 0, 1, FILL_WORD, ERR_NONE);
    // command pushes: plain, with bank number, top bit set at the last register
    add_probe(ACT_PORT_WR, 12'h004, '0, 32'h0012_3456, '0, 0, 0, '0, ERR_NONE);
    add_probe(ACT_PORT_WR, 12'h304, '0, 32'h7fff_ffff, '0, 0, 0, '0, ERR_NONE);
    add_probe(ACT_PORT_WR, 12'h3ff, '0, 32'hffff_ffff, '0, 0, 0, '0, ERR_NONE);
    // misaligned command write is dropped
    add_probe(ACT_PORT_WR, 12'h001, '0, 32'h0000_1234, '0, 0, 1, '0, ERR_NONE);
    // unknown registers
    add_probe(ACT_PORT_WR, OFF_CMD_LIMIT, '0, 32'h0000_0001, '0, 0, 1, '0, ERR_UNKNOWN);
    add_probe(ACT_PORT_WR, '1, '0, '1, '0, 0, 1, '0, ERR_UNKNOWN);
    add_probe(ACT_PORT_RD, OFF_WP_READ, '0, '0, '0, 0, 0, '0, ERR_NONE);
    add_probe(ACT_PROG_WR, '0, '0, 32'hdead_beef, '0, 0, 0, '0, ERR_NONE);
    add_probe(ACT_BUF_RD, '0, 15'd3, '0, '0, 0, 0, '0, ERR_NONE);
    // held program write and a spare action
    add_probe(ACT_PROG_WR, '0, '0, 32'h0000_1111, '0, 1, 1, '0, ERR_NONE);
    add_probe(ACT_SPARE_LO, '1, '1, '1, '1, 1, 1, '0, ERR_NONE);
    // last slot, then push past the end
    add_probe(ACT_PORT_WR, OFF_WP_LOAD, '0, 32'hfff1_fffc, '0, 0, 1, '0, ERR_NONE);
    add_probe(ACT_PROG_WR, '0, '0, '1, '0, 0, 0, '0, ERR_NONE);
    add_probe(ACT_PROG_WR, '0, '0, '0, '0, 0, 1, '0, ERR_PAST_END);
    add_probe(ACT_PORT_WR, '0, '0, 32'h8000_0000, '0, 0, 1, '0, ERR_PAST_END);
    add_probe(ACT_PORT_RD, OFF_WP_READ, '0, '0, '0, 0, 0, '0, ERR_NONE);
    add_probe(ACT_BUF_RD, '0, '1, '0, '0, 0, 0, '0, ERR_NONE);
    // read pointer load and read-back
    add_probe(ACT_PORT_WR, OFF_RP, '0, '1, '0, 0, 1, '0, ERR_NONE);
    add_probe(ACT_PORT_RD, OFF_RP, '0, '0, '0, 0, 1, 32'h000f_ffff, ERR_NONE);
    // masked write, then a spare action
    add_probe(ACT_BUF_WR, '0, '1, 32'ha5a5_a5a5, 32'h0ff0_0ff0, 0, 1, '0, ERR_NONE);
    add_probe(ACT_SPARE_HI, '0, '0, '0, '0, 0, 1, '0, ERR_NONE);
  endfunction

  // stimulus
  initial begin : stimulus
    gcp_req_t          r;
    logic [DATA_W-1:0] prd;
    logic [ERROR_W-1:0] perr;
    reply_t            want;
    int                hold_now;
    hold_now = -1;
    for (int i = 0; i < BUFFER_WORDS; i++) buf_img[i] = FILL_WORD;
    wr_ptr   = '0;
    rd_ptr   = '0;
    hold_bit = 1'b0;
    rst_ni               <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_wdata            <= 1'b0;
    req_bus.valid        <= 1'b0;
    req_bus.action       <= '0;
    req_bus.port_offset  <= '0;
    req_bus.buffer_index <= '0;
    req_bus.write_data   <= '0;
    req_bus.lane_mask    <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part
    build_probe_table();
    tx_rate = 2;
    foreach (probe_rows[i]) begin
      if (int'(probe_rows[i].hold) != hold_now) begin
        set_program_hold(probe_rows[i].hold);
        hold_now = probe_rows[i].hold;
      end
      r.action       = probe_rows[i].act;
      r.port_offset  = probe_rows[i].off;
      r.buffer_index = probe_rows[i].idx;
      r.write_data   = probe_rows[i].data;
      r.lane_mask    = probe_rows[i].mask;
      send_request(r, prd, perr);
      if (probe_rows[i].typed) begin
        want.rd  = probe_rows[i].rd;
        want.err = probe_rows[i].err;
      end else begin
        want.rd  = prd;
        want.err = perr;
      end
      owed_replies.insert(owed_replies.size(), want);
    end

    // random part, hold bit toggled between phases
    for (int p = 0; p < 4; p++) begin
      set_program_hold(p % 2 == 0);
      for (int n = 0; n < 100; n++) begin
        if (n % 32 == 0) tx_rate = $urandom_range(0, 3);
        if (p == 3 && n >= 50) calm = 1'b1;
        r = random_request();
        send_request(r, prd, perr);
        want.rd  = prd;
        want.err = perr;
        owed_replies.insert(owed_replies.size(), want);
      end
    end

    // drain
    req_bus.valid <= 1'b0;
    while (owed_replies.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // reply side: check each reply and pace ready
  initial begin : reply_sink
    int     stall_left;
    int     window;
    int     rate;
    bit     squeezed;
    reply_t want;
    stall_left = 0;
    window     = 0;
    rate       = 0;
    squeezed   = 1'b0;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
        replies_seen++;
        if (owed_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected reply: read_data %h error_code %0d",
                     rsp_bus.read_data, rsp_bus.error_code);
        end else begin
          want = owed_replies[0];
          owed_replies.delete(0);
          if (rsp_bus.read_data !== want.rd || rsp_bus.error_code !== want.err) begin
            mismatches++;
            if (mismatches <= 10)
              $display("reply %0d: read_data exp %h got %h, error_code exp %0d got %0d",
                       replies_seen, want.rd, rsp_bus.read_data, want.err,
                       rsp_bus.error_code);
          end
        end
      end
      // stall rate is redrawn for each window, rate 0 gives a clean stretch
      if (window == 0) begin
        window = 64;
        rate   = $urandom_range(0, 3);
      end
      window--;
      // one long hold-off so the block backs up into its request side
      if (!squeezed && replies_seen == 150) begin
        squeezed   = 1'b1;
        stall_left = 300;
      end
      if (calm) begin
        stall_left = 0;
        rsp_bus.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_bus.ready <= 1'b0;
      end else if (rate != 0 && $urandom_range(1, 16) <= rate) begin
        stall_left = $urandom_range(1, 7) - 1;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

endmodule
